>>> sv/i2c_mcr_pkg.sv
// Shared types and constants for the I2C master controller register unit.
// No dependencies; imported by i2c_mcr_step and i2c_master_controller_regs_unit.
`timescale 1ns / 1ps

package i2c_mcr_pkg;

    localparam int REG_COUNT_DEFAULT = 9;

    // Word indices of the registers with side effects.
    localparam logic [7:0] IX_CR1 = 8'd0;
    localparam logic [7:0] IX_CR2 = 8'd1;
    localparam logic [7:0] IX_DR  = 8'd4;
    localparam logic [7:0] IX_SR1 = 8'd5;
    localparam logic [7:0] IX_SR2 = 8'd6;

    localparam logic [15:0] CR1_PE    = 16'h0001;
    localparam logic [15:0] CR1_START = 16'h0100;
    localparam logic [15:0] CR1_STOP  = 16'h0200;
    localparam logic [15:0] CR1_ACK   = 16'h0400;

    localparam logic [15:0] CR2_ITERREN = 16'h0100;
    localparam logic [15:0] CR2_ITEVTEN = 16'h0200;
    localparam logic [15:0] CR2_ITBUFEN = 16'h0400;

    localparam logic [15:0] SR1_SB    = 16'h0001;
    localparam logic [15:0] SR1_ADDR  = 16'h0002;
    localparam logic [15:0] SR1_BTF   = 16'h0004;
    localparam logic [15:0] SR1_ADD10 = 16'h0008;
    localparam logic [15:0] SR1_STOPF = 16'h0010;
    localparam logic [15:0] SR1_RXNE  = 16'h0040;
    localparam logic [15:0] SR1_TXE   = 16'h0080;
    localparam logic [15:0] SR1_ERRS  = 16'hDF00;

    localparam logic [15:0] SR2_MSL  = 16'h0001;
    localparam logic [15:0] SR2_BUSY = 16'h0002;
    localparam logic [15:0] SR2_TRA  = 16'h0004;

    localparam logic [15:0] READ_OOR = 16'hFFFF;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  reg_index;
        logic [15:0] write_data;
        logic [7:0]  bus_rx_byte;
    } item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        bus_start;
        logic [6:0]  bus_address;
        logic        bus_is_read;
        logic        bus_send;
        logic [7:0]  bus_tx_byte;
        logic        bus_recv;
        logic        bus_end;
        logic        event_irq;
        logic        error_irq;
    } result_t;

    // Control state kept beside the register file.
    typedef struct packed {
        logic [7:0] rx_hold;
        logic       clear_armed;
        logic       stop_pending;
    } ctrl_t;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

endpackage

>>> sv/i2c_master_controller_regs_unit.sv
// I2C master controller register unit: one register access per word.
// Registered path from input acceptance to the result word: input register, then result register.
// Throughput: one word per cycle while m_tready holds; the access logic in i2c_mcr_step is combinational.
// Reset (rst_n low, asynchronous): register file, receive hold byte and flags clear to zero.
// Depends on i2c_mcr_pkg and i2c_mcr_step.
`timescale 1ns / 1ps

module i2c_master_controller_regs_unit #(
    parameter int REG_COUNT = i2c_mcr_pkg::REG_COUNT_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // reg_index[7:0], write_data[23:8], bus_rx_byte[31:24]
    input  logic [i2c_mcr_pkg::IN_TDATA_W-1:0]    s_tdata,
    // op[0]
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // read_data[15:0], bus_start[16], bus_address[23:17], bus_is_read[24], bus_send[25],
    // bus_tx_byte[33:26], bus_recv[34], bus_end[35], event_irq[36], error_irq[37], zero[39:38]
    output logic [i2c_mcr_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import i2c_mcr_pkg::*;

    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    result_t     out_res_reg;
    logic [15:0] regs_reg  [REG_COUNT];
    logic [15:0] regs_next [REG_COUNT];
    ctrl_t       ctrl_reg;
    ctrl_t       ctrl_next;
    result_t     res_next;
    logic        advance;

    // The input word moves on when the result register is free or is being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    i2c_mcr_step #(
        .REG_COUNT (REG_COUNT)
    ) u_step (
        .item      (in_item_reg),
        .regs      (regs_reg),
        .ctrl      (ctrl_reg),
        .regs_next (regs_next),
        .ctrl_next (ctrl_next),
        .result    (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= '0;
            for (int i = 0; i < REG_COUNT; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                ctrl_reg      <= ctrl_next;
                regs_reg      <= regs_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= item_t'({s_tuser, s_tdata[7:0], s_tdata[23:8], s_tdata[31:24]});
        end
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_res_reg.error_irq,
                       out_res_reg.event_irq,
                       out_res_reg.bus_end,
                       out_res_reg.bus_recv,
                       out_res_reg.bus_tx_byte,
                       out_res_reg.bus_send,
                       out_res_reg.bus_is_read,
                       out_res_reg.bus_address,
                       out_res_reg.bus_start,
                       out_res_reg.read_data};

    // A start and a data send are never caused by the same access.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_res_reg.bus_start && out_res_reg.bus_send))
        else $error("start and send reported together");

    // Any read that is processed leaves no stop pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_item_reg.op == OP_READ) |=> !ctrl_reg.stop_pending)
        else $error("stop still pending after a read");

    // A held input word is kept while the result side stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("input word lost during output stall");

endmodule

>>> sv/i2c_mcr_step.sv
// Combinational access logic: one register read or write against the current state.
// Depends on i2c_mcr_pkg.
`timescale 1ns / 1ps

module i2c_mcr_step #(
    parameter int REG_COUNT = i2c_mcr_pkg::REG_COUNT_DEFAULT
) (
    input  i2c_mcr_pkg::item_t   item,
    input  logic [15:0]          regs      [REG_COUNT],
    input  i2c_mcr_pkg::ctrl_t   ctrl,
    output logic [15:0]          regs_next [REG_COUNT],
    output i2c_mcr_pkg::ctrl_t   ctrl_next,
    output i2c_mcr_pkg::result_t result
);
    import i2c_mcr_pkg::*;

    localparam int IDX_W = $clog2(REG_COUNT);

    logic [15:0] cr1;
    logic [15:0] cr2;
    logic [15:0] dr;
    logic [15:0] sr1;
    logic [15:0] sr2;
    logic        in_range;
    logic [IDX_W-1:0] idx;
    logic [15:0] d;
    logic [7:0]  rx;

    assign in_range = item.reg_index < 8'(REG_COUNT);
    assign idx      = item.reg_index[IDX_W-1:0];
    assign d        = item.write_data;
    assign rx       = item.bus_rx_byte;

    always_comb
    begin
        cr1       = regs[IX_CR1[IDX_W-1:0]];
        dr        = regs[IX_DR[IDX_W-1:0]];
        sr1       = regs[IX_SR1[IDX_W-1:0]];
        sr2       = regs[IX_SR2[IDX_W-1:0]];
        ctrl_next = ctrl;
        result    = '0;

        if (item.op == OP_READ)
        begin
            result.read_data = in_range ? regs[idx] : READ_OOR;
            if (item.reg_index == IX_SR1)
            begin
                ctrl_next.clear_armed = 1'b1;
            end
            else if (item.reg_index == IX_SR2)
            begin
                if (ctrl.clear_armed)
                begin
                    sr1 = sr1 & ~SR1_ADDR;
                    ctrl_next.clear_armed = 1'b0;
                end
            end
            else if (item.reg_index == IX_DR)
            begin
                if ((sr1 & SR1_BTF) != '0)
                begin
                    if (ctrl.clear_armed)
                    begin
                        sr1 = sr1 & ~SR1_BTF;
                        ctrl_next.clear_armed = 1'b0;
                    end
                    dr = {8'd0, ctrl.rx_hold};
                end
                else
                begin
                    sr1 = sr1 & ~SR1_RXNE;
                    if (!ctrl.stop_pending)
                    begin
                        dr  = {8'd0, rx};
                        sr1 = sr1 | SR1_RXNE;
                        result.bus_recv = 1'b1;
                    end
                end
            end
            else
            begin
                ctrl_next.clear_armed = 1'b0;
            end

            // A requested stop is carried out by the next read of any index.
            if (ctrl.stop_pending)
            begin
                result.bus_end = 1'b1;
                cr1 = cr1 & ~CR1_STOP;
                sr1 = sr1 & ~(SR1_TXE | SR1_BTF);
                sr2 = sr2 & ~(SR2_MSL | SR2_BUSY | SR2_TRA);
                ctrl_next.stop_pending = 1'b0;
            end
        end
        else if (item.reg_index == IX_CR1)
        begin
            cr1 = d;
            if ((d & CR1_ACK) != '0 && (sr2 & SR2_MSL) != '0 && (sr2 & SR2_TRA) == '0)
            begin
                if ((sr1 & SR1_RXNE) == '0)
                begin
                    dr  = {8'd0, rx};
                    sr1 = sr1 | SR1_RXNE;
                    result.bus_recv = 1'b1;
                end
                else if ((sr1 & SR1_BTF) == '0)
                begin
                    ctrl_next.rx_hold = rx;
                    sr1 = sr1 | SR1_BTF;
                    result.bus_recv = 1'b1;
                end
            end
            if ((d & CR1_START) != '0)
            begin
                result.bus_end = 1'b1;
                cr1 = cr1 & ~CR1_START;
                sr1 = (sr1 | SR1_SB) & ~(SR1_TXE | SR1_BTF);
                sr2 = sr2 | SR2_MSL | SR2_BUSY;
            end
            if ((d & CR1_STOP) != '0)
            begin
                ctrl_next.stop_pending = 1'b1;
            end
            if ((d & CR1_PE) == '0)
            begin
                sr1 = '0;
                sr2 = '0;
            end
        end
        else if (item.reg_index == IX_DR)
        begin
            if ((sr1 & SR1_TXE) == '0)
            begin
                // Address phase: the word carries the target address and direction.
                result.bus_start   = 1'b1;
                result.bus_address = d[7:1];
                result.bus_is_read = d[0];
                sr1 = sr1 | SR1_ADDR;
                if (d[0])
                begin
                    sr2 = sr2 & ~SR2_TRA;
                    dr  = {8'd0, rx};
                    sr1 = sr1 | SR1_RXNE;
                    result.bus_recv = 1'b1;
                end
                else
                begin
                    sr2 = sr2 | SR2_TRA;
                    sr1 = (sr1 | SR1_TXE | SR1_BTF) & ~SR1_RXNE;
                end
            end
            else
            begin
                result.bus_send    = 1'b1;
                result.bus_tx_byte = d[7:0];
                sr1 = (sr1 & ~SR1_RXNE) | SR1_BTF;
            end
            sr1 = sr1 & ~SR1_SB;
        end

        regs_next = regs;
        regs_next[IX_CR1[IDX_W-1:0]] = cr1;
        regs_next[IX_DR[IDX_W-1:0]]  = dr;
        regs_next[IX_SR1[IDX_W-1:0]] = sr1;
        regs_next[IX_SR2[IDX_W-1:0]] = sr2;
        if (item.op == OP_WRITE && in_range && item.reg_index != IX_CR1
            && item.reg_index != IX_DR)
        begin
            regs_next[idx] = d;
        end

        // A plain write to SR1 also counts towards the interrupt levels.
        sr1 = regs_next[IX_SR1[IDX_W-1:0]];
        cr2 = regs_next[IX_CR2[IDX_W-1:0]];
        if ((cr2 & CR2_ITEVTEN) != '0)
        begin
            result.event_irq = (sr1 & (SR1_SB | SR1_ADDR | SR1_ADD10 | SR1_STOPF | SR1_BTF)) != '0
                || ((cr2 & CR2_ITBUFEN) != '0 && (sr1 & (SR1_TXE | SR1_RXNE)) != '0);
        end
        if ((cr2 & CR2_ITERREN) != '0)
        begin
            result.error_irq = (sr1 & SR1_ERRS) != '0;
        end
    end

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the I2C master controller register unit.
// Drives register accesses over the stream ports and checks every result word against a
// predictor of the register file; depends on i2c_mcr_pkg and i2c_master_controller_regs_unit.
`timescale 1ns / 1ps

module testbench;

    import i2c_mcr_pkg::*;

    localparam int REG_COUNT    = REG_COUNT_DEFAULT;
    localparam int DIR_ROWS     = 26;
    localparam int RANDOM_ITEMS = 820;

    typedef struct packed {
        op_t         op;
        logic [7:0]  idx;
        logic [15:0] wdata;
        logic [7:0]  rx;
        logic        typed;
        logic [15:0] rd;
    } access_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Mirror of the block's state, kept in step by apply_access.
    logic [15:0] mirror [REG_COUNT];
    logic [7:0]  hold_byte;
    logic        clear_armed_m;
    logic        stop_pending_m;

    access_t access_plan [$];
    result_t expected_words [$];
    int      mismatches;

    // Fields: op, index, write data, bus byte, read data typed in, read data.
    access_t directed [DIR_ROWS] = '{
        '{OP_READ,  IX_CR1, 16'h0000, 8'h00, 1'b1, 16'h0000},
        '{OP_READ,  8'hFF,  16'hFFFF, 8'hFF, 1'b1, READ_OOR},
        '{OP_WRITE, 8'hFF,  16'hFFFF, 8'hFF, 1'b1, 16'h0000},
        '{OP_WRITE, IX_CR2, 16'h0700, 8'h00, 1'b1, 16'h0000},
        '{OP_WRITE, IX_CR1, 16'h0101, 8'h00, 1'b1, 16'h0000},
        '{OP_READ,  IX_SR1, 16'h0000, 8'h00, 1'b0, 16'h0000},
        '{OP_WRITE, IX_DR,  16'h00A0, 8'h00, 1'b0, 16'h0000},
        '{OP_READ,  IX_SR1, 16'h0000, 8'h00, 1'b0, 16'h0000},
        '{OP_READ,  IX_SR2, 16'h0000, 8'h00, 1'b0, 16'h0000},
        '{OP_WRITE, IX_DR,  16'hFF5A, 8'h00, 1'b0, 16'h0000},
        '{OP_WRITE, IX_DR,  16'h00FF, 8'h00, 1'b0, 16'h0000},
        '{OP_WRITE, IX_CR1, 16'h0201, 8'h00, 1'b0, 16'h0000},
        '{OP_READ,  IX_DR,  16'h0000, 8'h33, 1'b0, 16'h0000},
        '{OP_WRITE, IX_CR1, 16'h0101, 8'h00, 1'b0, 16'h0000},
        '{OP_WRITE, IX_DR,  16'h00FF, 8'hC3, 1'b0, 16'h0000},
        '{OP_WRITE, IX_CR1, 16'h0401, 8'h5E, 1'b0, 16'h0000},
        '{OP_READ,  IX_SR1, 16'h0000, 8'h00, 1'b0, 16'h0000},
        '{OP_READ,  IX_DR,  16'h0000, 8'h99, 1'b0, 16'h0000},
        '{OP_READ,  IX_DR,  16'h0000, 8'hFF, 1'b0, 16'h0000},
        '{OP_WRITE, IX_CR1, 16'h0201, 8'h00, 1'b0, 16'h0000},
        '{OP_READ,  IX_DR,  16'h0000, 8'h77, 1'b0, 16'h0000},
        '{OP_WRITE, IX_SR1, 16'hDF1F, 8'h00, 1'b0, 16'h0000},
        '{OP_WRITE, IX_CR1, 16'h0000, 8'h00, 1'b0, 16'h0000},
        '{OP_WRITE, 8'd8,   16'hFFFF, 8'h00, 1'b1, 16'h0000},
        '{OP_READ,  8'd8,   16'h0000, 8'h00, 1'b1, 16'hFFFF},
        '{OP_READ,  8'd9,   16'h0000, 8'h00, 1'b1, READ_OOR}
    };

    i2c_master_controller_regs_unit #(
        .REG_COUNT(REG_COUNT)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Works out the result word of one access and moves the mirror on.
    function automatic result_t apply_access(input access_t a);
        result_t     r;
        logic [15:0] ev;
        r = '0;
        if (a.op == OP_READ) begin
            r.read_data = (a.idx < REG_COUNT) ? mirror[a.idx] : READ_OOR;
            if (a.idx == IX_SR1) begin
                clear_armed_m = 1'b1;
            end else if (a.idx == IX_SR2) begin
                if (clear_armed_m) begin
                    mirror[IX_SR1] &= ~SR1_ADDR;
                    clear_armed_m = 1'b0;
                end
            end else if (a.idx == IX_DR) begin
                if ((mirror[IX_SR1] & SR1_BTF) != 0) begin
                    if (clear_armed_m) begin
                        mirror[IX_SR1] &= ~SR1_BTF;
                        clear_armed_m = 1'b0;
                    end
                    mirror[IX_DR] = {8'h00, hold_byte};
                end else begin
                    mirror[IX_SR1] &= ~SR1_RXNE;
                    if (!stop_pending_m) begin
                        mirror[IX_DR] = {8'h00, a.rx};
                        mirror[IX_SR1] |= SR1_RXNE;
                        r.bus_recv = 1'b1;
                    end
                end
            end else begin
                clear_armed_m = 1'b0;
            end
            // A pending stop completes on any read, whatever the index.
            if (stop_pending_m) begin
                r.bus_end = 1'b1;
                mirror[IX_CR1] &= ~CR1_STOP;
                mirror[IX_SR1] &= ~(SR1_TXE | SR1_BTF);
                mirror[IX_SR2] &= ~(SR2_MSL | SR2_BUSY | SR2_TRA);
                stop_pending_m = 1'b0;
            end
        end else if (a.idx == IX_CR1) begin
            mirror[IX_CR1] = a.wdata;
            if ((a.wdata & CR1_ACK) != 0 && (mirror[IX_SR2] & SR2_MSL) != 0
                    && (mirror[IX_SR2] & SR2_TRA) == 0) begin
                if ((mirror[IX_SR1] & SR1_RXNE) == 0) begin
                    mirror[IX_DR] = {8'h00, a.rx};
                    mirror[IX_SR1] |= SR1_RXNE;
                    r.bus_recv = 1'b1;
                end else if ((mirror[IX_SR1] & SR1_BTF) == 0) begin
                    hold_byte = a.rx;
                    mirror[IX_SR1] |= SR1_BTF;
                    r.bus_recv = 1'b1;
                end
            end
            if ((a.wdata & CR1_START) != 0) begin
                r.bus_end = 1'b1;
                mirror[IX_CR1] &= ~CR1_START;
                mirror[IX_SR1] = (mirror[IX_SR1] | SR1_SB) & ~(SR1_TXE | SR1_BTF);
                mirror[IX_SR2] |= SR2_MSL | SR2_BUSY;
            end
            if ((a.wdata & CR1_STOP) != 0)
                stop_pending_m = 1'b1;
            if ((a.wdata & CR1_PE) == 0) begin
                mirror[IX_SR1] = 16'h0000;
                mirror[IX_SR2] = 16'h0000;
            end
        end else if (a.idx == IX_DR) begin
            // With TxE clear the word is the address byte; otherwise it is data.
            if ((mirror[IX_SR1] & SR1_TXE) == 0) begin
                r.bus_start   = 1'b1;
                r.bus_address = a.wdata[7:1];
                r.bus_is_read = a.wdata[0];
                mirror[IX_SR1] |= SR1_ADDR;
                if (a.wdata[0]) begin
                    mirror[IX_SR2] &= ~SR2_TRA;
                    mirror[IX_DR] = {8'h00, a.rx};
                    mirror[IX_SR1] |= SR1_RXNE;
                    r.bus_recv = 1'b1;
                end else begin
                    mirror[IX_SR2] |= SR2_TRA;
                    mirror[IX_SR1] = (mirror[IX_SR1] | SR1_TXE | SR1_BTF) & ~SR1_RXNE;
                end
            end else begin
                r.bus_send    = 1'b1;
                r.bus_tx_byte = a.wdata[7:0];
                mirror[IX_SR1] = (mirror[IX_SR1] & ~SR1_RXNE) | SR1_BTF;
            end
            mirror[IX_SR1] &= ~SR1_SB;
        end else if (a.idx < REG_COUNT) begin
            mirror[a.idx] = a.wdata;
        end

        ev = mirror[IX_SR1] & (SR1_SB | SR1_ADDR | SR1_ADD10 | SR1_STOPF | SR1_BTF);
        if ((mirror[IX_CR2] & CR2_ITBUFEN) != 0)
            ev |= mirror[IX_SR1] & (SR1_TXE | SR1_RXNE);
        r.event_irq = (mirror[IX_CR2] & CR2_ITEVTEN) != 0 && ev != 0;
        r.error_irq = (mirror[IX_CR2] & CR2_ITERREN) != 0 && (mirror[IX_SR1] & SR1_ERRS) != 0;
        return r;
    endfunction

    task automatic add_access(input op_t op, input logic [7:0] idx, input logic [15:0] d);
        access_t a;
        a = '{op, idx, d, 8'($urandom), 1'b0, 16'h0000};
        access_plan.push_back(a);
    endtask

    // One well-formed transfer: start, address, data phase, and usually a stop.
    task automatic add_transfer();
        logic        rd_dir;
        logic [15:0] extra;
        int          n;
        rd_dir = 1'($urandom);
        // Random bits everywhere but PE, START, STOP and ACK.
        extra  = 16'($urandom) & 16'hF8FE;
        n      = $urandom_range(0, 6);
        add_access(OP_WRITE, IX_CR1, CR1_PE | CR1_START | extra);
        if ($urandom_range(0, 3) != 0)
            add_access(OP_READ, IX_SR1, 16'($urandom));
        add_access(OP_WRITE, IX_DR, {8'($urandom), 7'($urandom), rd_dir});
        if ($urandom_range(0, 4) != 0) begin
            add_access(OP_READ, IX_SR1, 16'($urandom));
            add_access(OP_READ, IX_SR2, 16'($urandom));
        end
        repeat (n)
        begin
            if (rd_dir) begin
                case ($urandom_range(0, 3))
                    0: add_access(OP_WRITE, IX_CR1, CR1_PE | CR1_ACK | extra);
                    1: add_access(OP_READ, IX_DR, 16'($urandom));
                    2:
                    begin
                        add_access(OP_READ, IX_SR1, 16'($urandom));
                        add_access(OP_READ, IX_DR, 16'($urandom));
                    end
                    default: add_access(OP_READ, IX_SR2, 16'($urandom));
                endcase
            end else begin
                add_access(OP_WRITE, IX_DR, 16'($urandom));
                if ($urandom_range(0, 2) == 0)
                    add_access(OP_READ, IX_SR1, 16'($urandom));
            end
        end
        if ($urandom_range(0, 4) != 0) begin
            add_access(OP_WRITE, IX_CR1, CR1_PE | CR1_STOP | extra);
            add_access(OP_READ, rd_dir ? IX_DR : 8'($urandom_range(0, 9)), 16'($urandom));
        end
    endtask

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_len(input logic calm);
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned seen);
        if (want != seen) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, seen);
            mismatches++;
        end
    endtask

    // Result checker: each word is compared with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $display("%0t ns: result word expected none, got %h", $time, m_tdata);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                compare_field("read_data", want.read_data, m_tdata[15:0]);
                compare_field("bus_start", want.bus_start, m_tdata[16]);
                compare_field("bus_address", want.bus_address, m_tdata[23:17]);
                compare_field("bus_is_read", want.bus_is_read, m_tdata[24]);
                compare_field("bus_send", want.bus_send, m_tdata[25]);
                compare_field("bus_tx_byte", want.bus_tx_byte, m_tdata[33:26]);
                compare_field("bus_recv", want.bus_recv, m_tdata[34]);
                compare_field("bus_end", want.bus_end, m_tdata[35]);
                compare_field("event_irq", want.event_irq, m_tdata[36]);
                compare_field("error_irq", want.error_irq, m_tdata[37]);
            end
        end
    end

    // Receiver side: random back-pressure with calm stretches in between.
    initial
    begin
        int hold;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            hold = idle_len($urandom_range(0, 5) == 0);
            if (hold != 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        access_t row;
        result_t want;
        int      gap;
        logic    calm;
        int      pick;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        mismatches     = 0;
        hold_byte      = 8'h00;
        clear_armed_m  = 1'b0;
        stop_pending_m = 1'b0;
        calm           = 1'b0;
        foreach (mirror[k])
            mirror[k] = 16'h0000;

        foreach (directed[k])
            access_plan.push_back(directed[k]);
        while (access_plan.size() < DIR_ROWS + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                add_transfer();
            end else if (pick < 68) begin
                add_access(OP_WRITE, IX_CR2,
                           16'($urandom) | ($urandom_range(0, 3) != 0 ? 16'h0700 : 16'h0000));
            end else begin
                add_access(op_t'($urandom_range(0, 1)),
                           ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 8))
                                                      : 8'($urandom),
                           16'($urandom));
            end
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (access_plan[k])
        begin
            row = access_plan[k];
            if (k % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            gap = idle_len(calm);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= row.op;
            s_tdata  <= {row.rx, row.wdata, row.idx};
            do @(posedge clk); while (!s_tready);
            want = apply_access(row);
            if (row.typed)
                want.read_data = row.rd;
            expected_words.push_back(want);
            @(negedge clk);
        end
        s_tvalid <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
